@@ design/sobel_pkg.sv @@
// shared types and constants of the rgb sobel edge magnitude block
package sobel_pkg;

  // line buffer depth when the top level is not told otherwise
  localparam int MAX_WIDTH_DEFAULT = 1024;

  // register indexes on the configuration port
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int FW_BITS  = 11;
  localparam int FH_BITS  = 13;
  localparam int CFG_BITS = 13;

  localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [FH_BITS-1:0] HEIGHT_LIMIT       = 13'd4096;

  // sums of squares at or above 255*255 + 256 round to 256 or more: clamp
  localparam logic [20:0] SAT_LIMIT      = 21'd65281;
  localparam logic [15:0] ROOT_FIRST_BIT = 16'h4000;
  localparam logic [7:0]  EDGE_MAX       = 8'd255;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       flush;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic       frame_done;
  } edge_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DONE
  } state_t;

endpackage

@@ design/sobel_edge_magnitude_rgb.sv @@
// rgb sobel edge magnitude filter with line buffers in one synchronous memory
//
// Pixels come in raster order, one input beat per pixel; each beat yields at
// most one output beat, the gradient magnitude round(sqrt(gx^2 + gy^2)) of
// each color channel clamped to 255, for the pixel one row plus one pixel
// earlier. Neighbors outside the frame count as zero. After the last pixel of
// a frame the source sends frame_width + 1 beats with flush set (zero pixels)
// to drain the last row; frame_done marks the result of the frame's last
// pixel, and the next beat starts a new frame. Both rows of history sit in
// one MAX_WIDTH x 48 bit memory (upper and middle line side by side) that is
// read and written back once per pixel. A beat that yields no result occupies
// the block for a memory read, then write back and window shift; a beat that
// yields a result then also runs the gradient, square and sum steps and an 8
// step digit-by-digit square root shared by nothing but running for all three
// channels side by side, then waits until the output register is free. The
// output beat sits in its own register, so a new pixel is taken while a result
// waits. After reset the block first zeroes the line memory, one entry per
// cycle, all MAX_WIDTH entries, and takes no pixel until then; configuration
// writes are taken at any time but belong between frames. frame_width 0 acts
// as 1 and values above MAX_WIDTH act as MAX_WIDTH; frame_height 0 acts as 1.
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sobel_pkg::pixel_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sobel_pkg::edge_t              out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [sobel_pkg::CFG_BITS-1:0] cfg_data
);
  import sobel_pkg::*;

  // column index width and width of a count that can hold MAX_WIDTH itself
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > FW_BITS) ? WW : FW_BITS;

  // control state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [FW_BITS-1:0] frame_width_r, frame_width_nxt;
  logic [FH_BITS-1:0] frame_height_r, frame_height_nxt;
  logic [CW-1:0]     in_col_r, in_col_nxt;
  logic [1:0]        in_row_r, in_row_nxt;     // saturates at 2
  logic [CW-1:0]     out_col_r, out_col_nxt;
  logic [11:0]       out_row_r, out_row_nxt;
  logic              item_valid_r, item_valid_nxt;
  logic              done_r, done_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [23:0]       px_r;
  logic [CW-1:0]     col_r;
  logic [47:0]       rd_data_r;
  logic [23:0]       win_r [9];
  logic [9:0]        gx_abs_r [3];
  logic [9:0]        gy_abs_r [3];
  logic [19:0]       sq_x_r [3];
  logic [19:0]       sq_y_r [3];
  logic              sat_r [3];
  logic [16:0]       x_r [3];
  logic [16:0]       root_r [3];
  logic [15:0]       bit_r;
  edge_t             out_data_r;

  // line memory: upper line in the high half, middle line in the low half
  logic [47:0]       line_mem [MAX_WIDTH];
  logic              mem_we;
  logic [CW-1:0]     mem_waddr;
  logic [47:0]       mem_wdata;

  // handshake and datapath nets
  logic              in_take;
  logic              out_take;
  logic              out_load;
  logic [WW-1:0]     w_eff;
  logic [FH_BITS-1:0] h_eff;
  logic [CMPW-1:0]   fw_ext;
  logic              in_wrap;
  logic              top, bottom, left, right;
  logic [9:0]        gx_abs_c [3];
  logic [9:0]        gy_abs_c [3];
  logic [20:0]       sum_c [3];
  logic [16:0]       x_c [3];
  logic [16:0]       root_c [3];
  logic [7:0]        edge_c [3];

  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // effective frame size after clamping
  always_comb begin
    fw_ext = CMPW'(frame_width_r);
    if (fw_ext == '0) begin
      w_eff = WW'(1);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_ext);
    end
    if (frame_height_r == '0) begin
      h_eff = FH_BITS'(1);
    end else if (frame_height_r > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = frame_height_r;
    end
  end

  assign in_wrap = (WW'(in_col_r) + WW'(1)) >= w_eff;

  // border masks for the result pixel
  assign top    = (out_row_r == '0);
  assign bottom = ({1'b0, out_row_r} + 13'd1) >= h_eff;
  assign left   = (out_col_r == '0);
  assign right  = (WW'(out_col_r) + WW'(1)) >= w_eff;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_addr_r == CW'(MAX_WIDTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ:   state_nxt = item_valid_r ? ST_GRAD : ST_IDLE;
      ST_GRAD:   state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_ROOT;
      ST_ROOT:   if (bit_r[0]) state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = col_r;
    mem_wdata = {rd_data_r[23:0], px_r};
    out_load  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      ST_IDLE:  in_stall = 1'b0;
      ST_READ:  mem_we = 1'b1;
      ST_DONE:  out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // per channel arithmetic
  always_comb begin
    logic [9:0]  v [9];
    logic [11:0] gx, gy;
    logic [16:0] trial;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 9; i++) begin
        if ((i / 3 == 0 && top) || (i / 3 == 2 && bottom) ||
            (i % 3 == 0 && left) || (i % 3 == 2 && right)) begin
          v[i] = '0;
        end else begin
          v[i] = {2'b00, win_r[i][8*c +: 8]};
        end
      end
      gx = {2'b00, v[2]} + {1'b0, v[5], 1'b0} + {2'b00, v[8]}
         - {2'b00, v[0]} - {1'b0, v[3], 1'b0} - {2'b00, v[6]};
      gy = {2'b00, v[6]} + {1'b0, v[7], 1'b0} + {2'b00, v[8]}
         - {2'b00, v[0]} - {1'b0, v[1], 1'b0} - {2'b00, v[2]};
      gx_abs_c[c] = gx[11] ? 10'(-gx) : gx[9:0];
      gy_abs_c[c] = gy[11] ? 10'(-gy) : gy[9:0];
      sum_c[c] = {1'b0, sq_x_r[c]} + {1'b0, sq_y_r[c]};

      // one digit of the square root
      trial = root_r[c] + {1'b0, bit_r};
      if (x_r[c] >= trial) begin
        x_c[c]    = x_r[c] - trial;
        root_c[c] = (root_r[c] >> 1) + {1'b0, bit_r};
      end else begin
        x_c[c]    = x_r[c];
        root_c[c] = root_r[c] >> 1;
      end

      // round to nearest: remainder above root means s >= r*r + r + 1
      if (sat_r[c]) begin
        edge_c[c] = EDGE_MAX;
      end else if (x_r[c] > root_r[c]) begin
        edge_c[c] = (root_r[c] >= 17'(EDGE_MAX)) ? EDGE_MAX : 8'(root_r[c] + 17'd1);
      end else begin
        edge_c[c] = (root_r[c] > 17'(EDGE_MAX)) ? EDGE_MAX : root_r[c][7:0];
      end
    end
  end

  // counters and configuration
  always_comb begin
    clr_addr_nxt     = clr_addr_r;
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    in_col_nxt       = in_col_r;
    in_row_nxt       = in_row_r;
    out_col_nxt      = out_col_r;
    out_row_nxt      = out_row_r;
    item_valid_nxt   = item_valid_r;
    done_nxt         = done_r;
    out_valid_nxt    = out_valid_r;

    if (state_r == ST_CLEAR) clr_addr_nxt = clr_addr_r + CW'(1);

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_data[FW_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_data[FH_BITS-1:0];
        default: ;
      endcase
    end

    // input position and whether this pixel completes a window
    if (in_take) begin
      item_valid_nxt = (in_row_r == 2'd2) || (in_row_r == 2'd1 && in_col_r != '0);
      if (in_wrap) begin
        in_col_nxt = '0;
        if (in_row_r != 2'd2) in_row_nxt = in_row_r + 2'd1;
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end

    // output position; the frame's last result restarts the input and output position counters
    if (state_r == ST_GRAD) begin
      done_nxt = right && bottom;
      if (right) begin
        out_col_nxt = '0;
        if (bottom) begin
          out_row_nxt = '0;
          in_col_nxt  = '0;
          in_row_nxt  = '0;
        end else begin
          out_row_nxt = out_row_r + 12'd1;
        end
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      frame_width_r  <= FRAME_WIDTH_RESET;
      frame_height_r <= FRAME_HEIGHT_RESET;
      in_col_r       <= '0;
      in_row_r       <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      item_valid_r   <= 1'b0;
      done_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      state_r        <= state_nxt;
      clr_addr_r     <= clr_addr_nxt;
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      in_col_r       <= in_col_nxt;
      in_row_r       <= in_row_nxt;
      out_col_r      <= out_col_nxt;
      out_row_r      <= out_row_nxt;
      item_valid_r   <= item_valid_nxt;
      done_r         <= done_nxt;
      out_valid_r    <= out_valid_nxt;
      // shift the window left and bring in the new column
      if (state_r == ST_READ) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k*3]     <= win_r[k*3 + 1];
          win_r[k*3 + 1] <= win_r[k*3 + 2];
        end
        win_r[2] <= rd_data_r[47:24];
        win_r[5] <= rd_data_r[23:0];
        win_r[8] <= px_r;
      end
    end
  end

  // line memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) line_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= line_mem[in_col_r];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      px_r  <= in_data.flush ? 24'd0
                             : {in_data.blue_in, in_data.green_in, in_data.red_in};
      col_r <= in_col_r;
    end
    for (int c = 0; c < 3; c++) begin
      if (state_r == ST_GRAD) begin
        gx_abs_r[c] <= gx_abs_c[c];
        gy_abs_r[c] <= gy_abs_c[c];
      end
      if (state_r == ST_SQUARE) begin
        sq_x_r[c] <= gx_abs_r[c] * gx_abs_r[c];
        sq_y_r[c] <= gy_abs_r[c] * gy_abs_r[c];
      end
      if (state_r == ST_SUM) begin
        sat_r[c]  <= sum_c[c] >= SAT_LIMIT;
        x_r[c]    <= {1'b0, sum_c[c][15:0]};
        root_r[c] <= '0;
      end
      if (state_r == ST_ROOT) begin
        x_r[c]    <= x_c[c];
        root_r[c] <= root_c[c];
      end
    end
    if (state_r == ST_SUM) begin
      bit_r <= ROOT_FIRST_BIT;
    end else if (state_r == ST_ROOT) begin
      bit_r <= bit_r >> 2;
    end
    if (out_load) begin
      out_data_r.red_edge   <= edge_c[0];
      out_data_r.green_edge <= edge_c[1];
      out_data_r.blue_edge  <= edge_c[2];
      out_data_r.frame_done <= done_r;
    end
  end

endmodule
